// ===== hdl/qfts_pkg.sv =====
// Shared types, constants and codes for the two-stack queue.
package qfts_pkg;

   // Stack geometry
   localparam int STACK_DEPTH = 256;
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int CNT_W       = ADDR_W + 1;
   localparam int VALUE_W     = 32;

   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(STACK_DEPTH);

   // Most negative value, returned on a dequeue from an empty queue
   localparam logic signed [VALUE_W-1:0] EMPTY_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

   // Operation codes
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   // Request and response payloads
   typedef struct packed {
      logic                      operation;
      logic signed [VALUE_W-1:0] in_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic [1:0]                status;
   } rsp_type;

   // Control bundle for one stack memory
   typedef struct packed {
      logic               wr_en;
      logic [ADDR_W-1:0]  wr_addr;
      logic [VALUE_W-1:0] wr_data;
      logic               rd_en;
      logic [ADDR_W-1:0]  rd_addr;
   } stack_port_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_MOVE = 3'b010,
      ST_POP  = 3'b100
   } state_type;

endpackage

// ===== hdl/qfts_stack.sv =====
// Stack storage: one write port and one registered read port.
module qfts_stack (
   input  logic                         clock,
   input  qfts_pkg::stack_port_type     ctrl,
   output logic [qfts_pkg::VALUE_W-1:0] rd_data
);
   import qfts_pkg::*;

   logic [VALUE_W-1:0] mem [STACK_DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         mem[ctrl.wr_addr] <= ctrl.wr_data;
      end
      if (ctrl.rd_en) begin
         rd_data_ff <= mem[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/queue_from_two_stacks.sv =====
// Top level: FIFO queue built from an entry stack and an exit stack.
//
// Usage:
//   A request transfers at a rising edge with start high and busy low.
//   req_data.operation selects enqueue or dequeue; in_value is the value
//   to enqueue. Every request gives exactly one response, shown on rsp_data
//   for one cycle with rsp_strobe high. The receiver cannot hold it off.
// Responses and throughput:
//   Enqueue (stored or dropped): response in the cycle after the transfer,
//     busy stays low, so one enqueue per cycle.
//   Dequeue with data on the exit stack: response from the pop state.
//   Dequeue on an empty exit stack: the entry stack is moved over one entry
//     a cycle through the registered read port of the entry memory; the
//     oldest entry is not moved but is returned as the response.
//   Dequeue on an empty queue: response in the cycle after the transfer.
//   busy is high while a dequeue is in progress.
// Reset:
//   Synchronous reset empties both stacks (the counts clear) and returns the
//   sequencer to idle. Stack memory contents are not cleared.
module queue_from_two_stacks (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  qfts_pkg::req_type req_data,
   output logic              rsp_strobe,
   output qfts_pkg::rsp_type rsp_data
);
   import qfts_pkg::*;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   entry_count_ff, entry_count_in;
   logic [CNT_W-1:0]   exit_count_ff, exit_count_in;
   logic               strobe_ff, strobe_in;
   rsp_type            rsp_ff, rsp_in;
   stack_port_type     entry_port, exit_port;
   logic [VALUE_W-1:0] entry_rd_data, exit_rd_data;
   logic [CNT_W-1:0]   entry_dec, exit_dec;
   logic               accept;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign entry_dec = entry_count_ff - 1'b1;
   assign exit_dec  = exit_count_ff - 1'b1;

   // Stack memories
   qfts_stack u_entry_stack (
      .clock   (clock),
      .ctrl    (entry_port),
      .rd_data (entry_rd_data)
   );

   qfts_stack u_exit_stack (
      .clock   (clock),
      .ctrl    (exit_port),
      .rd_data (exit_rd_data)
   );

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      exit_count_in  = exit_count_ff;
      strobe_in      = 1'b0;
      rsp_in         = rsp_ff;
      entry_port     = '0;
      exit_port      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.operation == OP_ENQUEUE) begin
                  strobe_in        = 1'b1;
                  rsp_in.out_value = '0;
                  if (entry_count_ff == FULL_COUNT) begin
                     rsp_in.status = STATUS_FULL;
                  end else begin
                     rsp_in.status      = STATUS_DONE;
                     entry_port.wr_en   = 1'b1;
                     entry_port.wr_addr = entry_count_ff[ADDR_W-1:0];
                     entry_port.wr_data = req_data.in_value;
                     entry_count_in     = entry_count_ff + 1'b1;
                  end
               end else if (exit_count_ff != '0) begin
                  // pop straight from the exit stack
                  exit_port.rd_en   = 1'b1;
                  exit_port.rd_addr = exit_dec[ADDR_W-1:0];
                  exit_count_in     = exit_dec;
                  state_in          = ST_POP;
               end else if (entry_count_ff != '0) begin
                  // start moving the entry stack over, newest first
                  entry_port.rd_en   = 1'b1;
                  entry_port.rd_addr = entry_dec[ADDR_W-1:0];
                  entry_count_in     = entry_dec;
                  state_in           = ST_MOVE;
               end else begin
                  strobe_in        = 1'b1;
                  rsp_in.out_value = EMPTY_VALUE;
                  rsp_in.status    = STATUS_EMPTY;
               end
            end
         end
         ST_POP: begin
            strobe_in        = 1'b1;
            rsp_in.out_value = exit_rd_data;
            rsp_in.status    = STATUS_DONE;
            state_in         = ST_IDLE;
         end
         ST_MOVE: begin
            if (entry_count_ff == '0) begin
               // oldest entry: pushed and popped at once, so return it directly
               strobe_in        = 1'b1;
               rsp_in.out_value = entry_rd_data;
               rsp_in.status    = STATUS_DONE;
               state_in         = ST_IDLE;
            end else begin
               exit_port.wr_en    = 1'b1;
               exit_port.wr_addr  = exit_count_ff[ADDR_W-1:0];
               exit_port.wr_data  = entry_rd_data;
               exit_count_in      = exit_count_ff + 1'b1;
               entry_port.rd_en   = 1'b1;
               entry_port.rd_addr = entry_dec[ADDR_W-1:0];
               entry_count_in     = entry_dec;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         exit_count_ff  <= '0;
         strobe_ff      <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         exit_count_ff  <= exit_count_in;
         strobe_ff      <= strobe_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   // Checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (state_ff == ST_IDLE))
      else $error("response shown while a dequeue is still in progress");

   a_counts_bounded: assert property (@(posedge clock) disable iff (reset)
      (entry_count_ff <= FULL_COUNT) && (exit_count_ff <= FULL_COUNT))
      else $error("stack count beyond depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (rsp_strobe || busy))
      else $error("request transfer produced neither response nor work");

   a_move_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MOVE) |-> (exit_count_ff != FULL_COUNT))
      else $error("moving into a full exit stack");

endmodule
